[rtl/tmfs_pkg.sv]
// Shared constants for the triangle metrics pipeline: angle format,
// CORDIC arctangent table and fixed datapath widths of the angle unit.
// No dependencies.
package tmfs_pkg;

  localparam int ANGLE_W      = 16;  // angle output width, Q2.14
  localparam int CORDIC_STEPS = 24;  // vectoring iterations
  localparam int ZW           = 28;  // signed angle accumulator, 2^-24 rad units
  localparam int CW           = 34;  // signed CORDIC x/y width
  localparam int NORM_BITS    = 30;  // x and y are brought below 2^NORM_BITS
  localparam int FRAC_SHIFT   = 16;  // scale between root and area, and on N
  localparam int RND_SHIFT    = 10;  // 2^-24 rad to Q2.14
  localparam int RND_HALF     = 512;

  localparam logic signed [ZW-1:0] HALF_PI_U24 = 28'sd26353589;

  localparam logic signed [ZW-1:0] ATAN_U24 [CORDIC_STEPS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

endpackage

[rtl/tmfs_if.sv]
// Valid/ready channel interfaces for the triangle metrics block:
// side lengths in, metrics out. Depends on tmfs_pkg.
interface tmfs_in_if #(parameter int SIDE_WIDTH = 16);
  logic                  valid;
  logic                  ready;
  logic [SIDE_WIDTH-1:0] side_a;
  logic [SIDE_WIDTH-1:0] side_b;
  logic [SIDE_WIDTH-1:0] side_c;

  modport source (output valid, side_a, side_b, side_c, input ready);
  modport sink   (input valid, side_a, side_b, side_c, output ready);
endinterface

interface tmfs_out_if #(parameter int SIDE_WIDTH = 16);
  logic                             valid;
  logic                             ready;
  logic [SIDE_WIDTH+1:0]            perimeter;
  logic [SIDE_WIDTH-1:0]            longest_side;
  logic [2*SIDE_WIDTH:0]            area;
  logic [tmfs_pkg::ANGLE_W-1:0]     angle_a;
  logic [tmfs_pkg::ANGLE_W-1:0]     angle_b;
  logic [tmfs_pkg::ANGLE_W-1:0]     angle_c;
  logic                             valid_res;

  modport source (output valid, perimeter, longest_side, area, angle_a, angle_b, angle_c,
                  valid_res, input ready);
  modport sink   (input valid, perimeter, longest_side, area, angle_a, angle_b, angle_c,
                  valid_res, output ready);
endinterface

[rtl/triangle_metrics_from_sides.sv]
// Triangle metrics from three sides: perimeter, longest side, 4x Heron area
// and the three angles. Depends on tmfs_pkg and the channels in tmfs_if.
//
// Usage: side lengths enter on item_i, one triangle per item; one result
// item per triangle leaves on res_o in the same order. Both channels are
// valid/ready; an item moves when valid and ready are high at a clock edge.
// Items pass the Heron stages, RB = 2*SIDE_WIDTH + 19 square root steps,
// setup, L = clog2(RB) normalize levels, CORDIC and the output register.
// Throughput is one item per cycle unless res_o stalls; every stage holds
// one item, and the longest stage is one wide compare and subtract of the
// bit-serial square root or one 35x17 partial product of the Heron product.
// Sides that do not form a proper triangle give valid_res = 0 with area and
// angles forced to zero; perimeter and longest side are still given.
// Reset clears all stage valid bits at once; the block takes items in the
// first cycle after reset. When res_o stalls, the whole pipeline holds and
// item_i.ready drops until the output item is taken.
module triangle_metrics_from_sides #(
  parameter int SIDE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tmfs_in_if.sink    item_i,
  tmfs_out_if.source res_o
);
  import tmfs_pkg::*;

  localparam int W    = SIDE_WIDTH;
  localparam int PW   = W + 2;          // perimeter
  localparam int TW   = W + 1;          // Heron difference terms
  localparam int SQW  = 2 * W;          // squares of sides
  localparam int NW   = 2 * W + 2;      // signed cosine numerators
  localparam int M1W  = PW + TW;
  localparam int M2W  = 2 * TW;
  localparam int HLO  = TW;             // low part of m2
  localparam int HHI  = M2W - HLO;
  localparam int PLW  = M1W + HLO;
  localparam int PHW  = M1W + HHI;
  localparam int HW   = M1W + M2W;      // 16 * area^2
  localparam int RB   = (HW + 33) / 2;  // root bits of 16*area^2 * 2^32
  localparam int RW   = RB + 2;
  localparam int VW   = RB;             // CORDIC input vector width before scaling
  localparam int AW   = 2 * W + 1;
  localparam int L    = $clog2(VW);
  localparam int NST  = 4 + RB + 1 + (L + 1) + CORDIC_STEPS + 1;

  typedef struct packed {
    logic [PW-1:0] per;
    logic [W-1:0]  mx;
    logic          ok;
  } com_t;

  typedef struct packed {
    com_t                   com;
    logic [2:0][TW-1:0]     t;
    logic [2:0][SQW-1:0]    sq;
  } s1_t;

  typedef struct packed {
    com_t                com;
    logic [M1W-1:0]      m1;
    logic [M2W-1:0]      m2;
    logic [2:0][NW-1:0]  n;
  } s2_t;

  typedef struct packed {
    com_t                com;
    logic [PLW-1:0]      pl;
    logic [PHW-1:0]      ph;
    logic [2:0][NW-1:0]  n;
  } s3_t;

  typedef struct packed {
    com_t                com;
    logic [HW-1:0]       prod;
    logic [2:0][NW-1:0]  n;
  } s4_t;

  typedef struct packed {
    com_t                com;
    logic [RW-1:0]       rem;
    logic [RB-1:0]       root;
    logic [2*RB-1:0]     rad;
    logic [2:0][NW-1:0]  n;
  } sq_t;

  typedef struct packed {
    com_t                com;
    logic [AW-1:0]       area;
    logic [2:0][VW-1:0]  x;
    logic [2:0][VW-1:0]  y;
    logic [2:0]          hb;
  } nm_t;

  typedef struct packed {
    com_t                com;
    logic [AW-1:0]       area;
    logic [2:0][CW-1:0]  x;
    logic [2:0][CW-1:0]  y;
    logic [2:0][ZW-1:0]  z;
    logic [2:0]          hb;
  } cd_t;

  typedef struct packed {
    com_t                     com;
    logic [AW-1:0]            area;
    logic [2:0][ANGLE_W-1:0]  ang;
  } out_t;

  logic           adv;
  logic [NST-1:0] vld_q;

  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  sq_t  sq_src [RB];
  sq_t  sq_d [RB];
  sq_t  sq_q [RB];
  nm_t  st_d, st_q;
  nm_t  nm_src [L+1];
  nm_t  nm_d [L+1];
  nm_t  nm_q [L+1];
  cd_t  cd_src [CORDIC_STEPS];
  cd_t  cd_d [CORDIC_STEPS];
  cd_t  cd_q [CORDIC_STEPS];
  out_t out_d, out_q;

  // Advance every stage unless a finished item waits at the output
  assign adv          = !vld_q[NST-1] || res_o.ready;
  assign item_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], item_i.valid};
    end
  end

  // Stage 1: perimeter, maximum, triangle check, difference terms, squares
  always_comb begin
    logic [W-1:0] a, b, c, ab;
    a  = item_i.side_a;
    b  = item_i.side_b;
    c  = item_i.side_c;
    ab = (a > b) ? a : b;
    s1_d.com.per = PW'(a) + PW'(b) + PW'(c);
    s1_d.com.mx  = (c > ab) ? c : ab;
    s1_d.com.ok  = (a != '0) && (b != '0) && (c != '0) &&
                   (TW'(a) < TW'(b) + TW'(c)) &&
                   (TW'(b) < TW'(a) + TW'(c)) &&
                   (TW'(c) < TW'(a) + TW'(b));
    s1_d.t[0]  = TW'(b) + TW'(c) - TW'(a);
    s1_d.t[1]  = TW'(a) + TW'(c) - TW'(b);
    s1_d.t[2]  = TW'(a) + TW'(b) - TW'(c);
    s1_d.sq[0] = SQW'(a) * SQW'(a);
    s1_d.sq[1] = SQW'(b) * SQW'(b);
    s1_d.sq[2] = SQW'(c) * SQW'(c);
  end

  // Stage 2: pair up the Heron factors, form the cosine numerators
  always_comb begin
    s2_d.com  = s1_q.com;
    s2_d.m1   = M1W'(s1_q.com.per) * M1W'(s1_q.t[0]);
    s2_d.m2   = M2W'(s1_q.t[1]) * M2W'(s1_q.t[2]);
    s2_d.n[0] = NW'(s1_q.sq[1]) + NW'(s1_q.sq[2]) - NW'(s1_q.sq[0]);
    s2_d.n[1] = NW'(s1_q.sq[0]) + NW'(s1_q.sq[2]) - NW'(s1_q.sq[1]);
    s2_d.n[2] = NW'(s1_q.sq[0]) + NW'(s1_q.sq[1]) - NW'(s1_q.sq[2]);
  end

  // Stage 3: partial products of the last multiplication
  always_comb begin
    s3_d.com = s2_q.com;
    s3_d.n   = s2_q.n;
    s3_d.pl  = PLW'(s2_q.m1) * PLW'(s2_q.m2[HLO-1:0]);
    s3_d.ph  = PHW'(s2_q.m1) * PHW'(s2_q.m2[M2W-1:HLO]);
  end

  // Stage 4: sum the partial products into 16*area^2
  always_comb begin
    s4_d.com  = s3_q.com;
    s4_d.n    = s3_q.n;
    s4_d.prod = HW'(s3_q.pl) + (HW'(s3_q.ph) << HLO);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  // Square root of 16*area^2 * 2^32, one root bit per stage
  always_comb begin
    sq_src[0].com  = s4_q.com;
    sq_src[0].n    = s4_q.n;
    sq_src[0].rem  = '0;
    sq_src[0].root = '0;
    sq_src[0].rad  = {{(2*RB-HW-32){1'b0}}, s4_q.prod, 32'b0};
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    if (j > 0) begin : g_link
      assign sq_src[j] = sq_q[j-1];
    end

    always_comb begin
      logic [RW-1:0] remsh, trial;
      logic          ge;
      remsh = {sq_src[j].rem[RW-3:0], sq_src[j].rad[2*RB-1 -: 2]};
      trial = {sq_src[j].root, 2'b01};
      ge    = (remsh >= trial);
      sq_d[j]      = sq_src[j];
      sq_d[j].rem  = ge ? (remsh - trial) : remsh;
      sq_d[j].root = {sq_src[j].root[RB-2:0], ge};
      sq_d[j].rad  = sq_src[j].rad << 2;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[j] <= sq_d[j];
      end
    end
  end

  // Setup: area, and the CORDIC vector of each angle (turned by -pi/2 for N < 0)
  always_comb begin
    logic [RB-1:0] root;
    logic [NW-1:0] mag;
    logic [VW-1:0] nsh;
    root        = sq_q[RB-1].root;
    st_d.com    = sq_q[RB-1].com;
    st_d.area   = sq_q[RB-1].com.ok ? root[FRAC_SHIFT +: AW] : '0;
    for (int k = 0; k < 3; k++) begin
      st_d.hb[k] = sq_q[RB-1].n[k][NW-1];
      mag        = st_d.hb[k] ? (~sq_q[RB-1].n[k] + 1'b1) : sq_q[RB-1].n[k];
      nsh        = VW'({mag[NW-2:0], {FRAC_SHIFT{1'b0}}});
      st_d.x[k]  = st_d.hb[k] ? root : nsh;
      st_d.y[k]  = st_d.hb[k] ? nsh : root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q <= st_d;
    end
  end

  // Normalize: greedy binary shifts while the vector stays at 2^30 or more,
  // then one final shift that brings it below
  assign nm_src[0] = st_q;

  for (genvar m = 0; m <= L; m++) begin : g_norm
    localparam int SH  = (m < L) ? (2 ** (L - 1 - m)) : 1;
    localparam int LIM = (m < L) ? (NORM_BITS + SH) : NORM_BITS;

    if (m > 0) begin : g_link
      assign nm_src[m] = nm_q[m-1];
    end

    always_comb begin
      logic [VW-1:0] v;
      nm_d[m] = nm_src[m];
      for (int k = 0; k < 3; k++) begin
        v = nm_src[m].x[k] | nm_src[m].y[k];
        if (|(v >> LIM)) begin
          nm_d[m].x[k] = nm_src[m].x[k] >> SH;
          nm_d[m].y[k] = nm_src[m].y[k] >> SH;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        nm_q[m] <= nm_d[m];
      end
    end
  end

  // CORDIC vectoring, one iteration per stage, three lanes side by side
  always_comb begin
    cd_src[0].com  = nm_q[L].com;
    cd_src[0].area = nm_q[L].area;
    cd_src[0].hb   = nm_q[L].hb;
    for (int k = 0; k < 3; k++) begin
      cd_src[0].x[k] = {{(CW-NORM_BITS){1'b0}}, nm_q[L].x[k][NORM_BITS-1:0]};
      cd_src[0].y[k] = {{(CW-NORM_BITS){1'b0}}, nm_q[L].y[k][NORM_BITS-1:0]};
      cd_src[0].z[k] = '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    if (i > 0) begin : g_link
      assign cd_src[i] = cd_q[i-1];
    end

    always_comb begin
      logic signed [CW-1:0] xs, ys, dx, dy;
      logic signed [ZW-1:0] zs;
      cd_d[i] = cd_src[i];
      for (int k = 0; k < 3; k++) begin
        xs = $signed(cd_src[i].x[k]);
        ys = $signed(cd_src[i].y[k]);
        zs = $signed(cd_src[i].z[k]);
        // shifts truncate toward zero
        dx = xs[CW-1] ? -((-xs) >>> i) : (xs >>> i);
        dy = ys[CW-1] ? -((-ys) >>> i) : (ys >>> i);
        if (!ys[CW-1]) begin
          cd_d[i].x[k] = xs + dy;
          cd_d[i].y[k] = ys - dx;
          cd_d[i].z[k] = zs + ATAN_U24[i];
        end else begin
          cd_d[i].x[k] = xs - dy;
          cd_d[i].y[k] = ys + dx;
          cd_d[i].z[k] = zs - ATAN_U24[i];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cd_q[i] <= cd_d[i];
      end
    end
  end

  // Final: add the quarter turn where N < 0, clamp at zero, round to Q2.14
  always_comb begin
    logic signed [ZW-1:0] tot;
    logic [ZW-1:0]        rnd;
    out_d.com  = cd_q[CORDIC_STEPS-1].com;
    out_d.area = cd_q[CORDIC_STEPS-1].area;
    for (int k = 0; k < 3; k++) begin
      tot = $signed(cd_q[CORDIC_STEPS-1].z[k]);
      if (cd_q[CORDIC_STEPS-1].hb[k]) begin
        tot = tot + HALF_PI_U24;
      end
      if (tot < 0) begin
        tot = '0;
      end
      rnd = $unsigned(tot) + ZW'(RND_HALF);
      out_d.ang[k] = cd_q[CORDIC_STEPS-1].com.ok ? rnd[RND_SHIFT +: ANGLE_W] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  // Drive the result channel from the output register
  assign res_o.valid        = vld_q[NST-1];
  assign res_o.perimeter    = out_q.com.per;
  assign res_o.longest_side = out_q.com.mx;
  assign res_o.area         = out_q.area;
  assign res_o.angle_a      = out_q.ang[0];
  assign res_o.angle_b      = out_q.ang[1];
  assign res_o.angle_c      = out_q.ang[2];
  assign res_o.valid_res    = out_q.com.ok;

endmodule

[rtl/tmfs_checker.sv]
// Port-level checks for the triangle metrics block and the bind that
// attaches them to the top level. Depends on tmfs_pkg.
module tmfs_checker #(
  parameter int SIDE_WIDTH = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [SIDE_WIDTH+1:0]              perimeter_i,
  input logic [SIDE_WIDTH-1:0]              longest_side_i,
  input logic [2*SIDE_WIDTH:0]              area_i,
  input logic [tmfs_pkg::ANGLE_W-1:0]       angle_a_i,
  input logic [tmfs_pkg::ANGLE_W-1:0]       angle_b_i,
  input logic [tmfs_pkg::ANGLE_W-1:0]       angle_c_i,
  input logic                               valid_res_i
);

  // Hold a stalled output item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  // Accept input whenever the output register is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  // Zero area and angles for an improper triangle
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !valid_res_i |-> area_i == '0 && angle_a_i == '0 &&
      angle_b_i == '0 && angle_c_i == '0)
    else $error("improper triangle with nonzero metrics");

  // Longest side of a proper triangle is below half the perimeter
  a_valid_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && valid_res_i |-> perimeter_i > {1'b0, longest_side_i, 1'b0})
    else $error("proper triangle flagged with inconsistent sides");

  // Reset low at a clock edge leaves no output item valid just after it
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind triangle_metrics_from_sides tmfs_checker #(.SIDE_WIDTH(SIDE_WIDTH)) u_tmfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .perimeter_i    (res_o.perimeter),
  .longest_side_i (res_o.longest_side),
  .area_i         (res_o.area),
  .angle_a_i      (res_o.angle_a),
  .angle_b_i      (res_o.angle_b),
  .angle_c_i      (res_o.angle_c),
  .valid_res_i    (res_o.valid_res)
);

[tb/testbench.sv]
// Self-checking testbench for triangle_metrics_from_sides: drives side triples,
// predicts perimeter, longest side, 4x Heron area, CORDIC angles, and checks them.
// Depends on tmfs_pkg, tmfs_if and the RTL top level.
module testbench;
  import tmfs_pkg::*;

  localparam int SW       = 16;
  localparam int N_RANDOM = 1400;
  localparam int DRAIN_AT = 700;
  localparam int CALM_TAIL = 200;
  localparam int LATENCY  = 88;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    logic [SW-1:0] c;
  } sides_t;

  typedef struct packed {
    logic [SW+1:0]      perimeter;
    logic [SW-1:0]      longest;
    logic [2*SW:0]      area;
    logic [ANGLE_W-1:0] ang_a;
    logic [ANGLE_W-1:0] ang_b;
    logic [ANGLE_W-1:0] ang_c;
    logic               proper;
  } metrics_t;

  logic clk_i;
  logic rst_ni;

  tmfs_in_if  #(.SIDE_WIDTH(SW)) item_if ();
  tmfs_out_if #(.SIDE_WIDTH(SW)) res_if ();

  triangle_metrics_from_sides #(.SIDE_WIDTH(SW)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .res_o  (res_if)
  );

  sides_t   pending_q[$];
  metrics_t metrics_q[$];
  int       err_cnt;
  int       accepted_cnt;
  int       checked_cnt;
  int       proper_cnt;
  int       obtuse_cnt;
  longint   cycle_cnt;
  bit       drained;
  int       send_gap;
  int       recv_gap;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.side_a = '0;
    item_if.side_b = '0;
    item_if.side_c = '0;
    res_if.ready = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  // Exact integer square root, floor
  function automatic logic [127:0] isqrt128(input logic [127:0] num);
    logic [127:0] rem;
    logic [127:0] root;
    logic [127:0] bitv;
    logic [127:0] t;
    rem = num;
    root = '0;
    bitv = 128'd1 << 126;
    while (bitv != 0) begin
      t = root + bitv;
      if (rem >= t) begin
        rem = rem - t;
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint shift_toward_zero(input longint v, input int sh);
    return (v >= 0) ? (v >>> sh) : -((-v) >>> sh);
  endfunction

  // Angle opposite the side with square opp, by CORDIC vectoring on (N, S)
  function automatic logic [ANGLE_W-1:0] opposite_angle(input logic [127:0] p,
                                                        input logic [127:0] q,
                                                        input logic [127:0] opp,
                                                        input logic [127:0] root);
    logic [127:0] sum;
    logic [127:0] x;
    logic [127:0] y;
    longint xi;
    longint yi;
    longint xo;
    longint z;
    longint total;
    sum = p + q;
    z = 0;
    if (sum >= opp) begin
      x = (sum - opp) << FRAC_SHIFT;
      y = root;
    end else begin
      x = root;
      y = (opp - sum) << FRAC_SHIFT;
      z = HALF_PI_U24;
    end
    // Normalize both components together
    while (x >= (128'd1 << NORM_BITS) || y >= (128'd1 << NORM_BITS)) begin
      x = x >> 1;
      y = y >> 1;
    end
    xi = longint'(x[63:0]);
    yi = longint'(y[63:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xo = xi;
      if (yi >= 0) begin
        xi += shift_toward_zero(yi, i);
        yi -= shift_toward_zero(xo, i);
        z += longint'(ATAN_U24[i]);
      end else begin
        xi -= shift_toward_zero(yi, i);
        yi += shift_toward_zero(xo, i);
        z -= longint'(ATAN_U24[i]);
      end
    end
    total = (z < 0) ? 0 : z;
    return ANGLE_W'((total + RND_HALF) >>> RND_SHIFT);
  endfunction

  function automatic metrics_t triangle_metrics(input sides_t s);
    metrics_t m;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] c;
    logic [127:0] heron;
    logic [127:0] root;
    logic [127:0] area_w;
    a = s.a;
    b = s.b;
    c = s.c;
    m = '0;
    m.perimeter = (SW+2)'(a + b + c);
    m.longest = s.a;
    if (s.b > m.longest) m.longest = s.b;
    if (s.c > m.longest) m.longest = s.c;
    m.proper = (a != 0) && (b != 0) && (c != 0) && (a < b + c) && (b < a + c) && (c < a + b);
    if (m.proper) begin
      heron = (a + b + c) * (b + c - a) * (a + c - b) * (a + b - c);
      root = isqrt128(heron << 32);
      area_w = root >> FRAC_SHIFT;
      m.area = area_w[2*SW:0];
      m.ang_a = opposite_angle(b * b, c * c, a * a, root);
      m.ang_b = opposite_angle(a * a, c * c, b * b, root);
      m.ang_c = opposite_angle(a * a, b * b, c * c, root);
    end
    return m;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    err_cnt++;
    $display("mismatch on result %0d: %s got %0d expected %0d", checked_cnt, what, got, want);
  endtask

  // Random proper triangle with sides of a random magnitude, in random order
  function automatic sides_t random_triangle();
    sides_t s;
    int unsigned bits;
    int unsigned u;
    int unsigned v;
    int unsigned w;
    int unsigned lo;
    int unsigned hi;
    int unsigned mask;
    bits = $urandom_range(1, SW);
    mask = (1 << bits) - 1;
    u = ($urandom & mask) | 1;
    v = ($urandom & mask) | 1;
    lo = (u > v) ? u - v + 1 : v - u + 1;
    hi = u + v - 1;
    if (hi > 65535) hi = 65535;
    w = $urandom_range(lo, hi);
    case ($urandom_range(0, 2))
      0: s = '{a: SW'(u), b: SW'(v), c: SW'(w)};
      1: s = '{a: SW'(w), b: SW'(u), c: SW'(v)};
      default: s = '{a: SW'(v), b: SW'(w), c: SW'(u)};
    endcase
    return s;
  endfunction

  // Fill the queue: directed corners first, then random triangles and noise
  initial begin
    sides_t s;
    int k;
    pending_q.push_back('{a: 0, b: 0, c: 0});
    pending_q.push_back('{a: 0, b: 5, c: 5});
    pending_q.push_back('{a: 5, b: 0, c: 5});
    pending_q.push_back('{a: 5, b: 5, c: 0});
    pending_q.push_back('{a: 1, b: 1, c: 1});
    pending_q.push_back('{a: 3, b: 4, c: 5});
    pending_q.push_back('{a: 5, b: 3, c: 4});
    pending_q.push_back('{a: 65535, b: 65535, c: 65535});
    pending_q.push_back('{a: 65535, b: 65535, c: 1});
    pending_q.push_back('{a: 1, b: 65535, c: 65535});
    pending_q.push_back('{a: 65535, b: 1, c: 65535});
    pending_q.push_back('{a: 10, b: 4, c: 6});
    pending_q.push_back('{a: 4, b: 10, c: 6});
    pending_q.push_back('{a: 4, b: 6, c: 10});
    pending_q.push_back('{a: 9, b: 4, c: 6});
    pending_q.push_back('{a: 1000, b: 1000, c: 1999});
    pending_q.push_back('{a: 65535, b: 32768, c: 32768});
    pending_q.push_back('{a: 1, b: 1, c: 65535});
    pending_q.push_back('{a: 65535, b: 65534, c: 65533});
    pending_q.push_back('{a: 32768, b: 21845, c: 43690});
    pending_q.push_back('{a: 2, b: 2, c: 3});
    for (k = 0; k < N_RANDOM; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        s = random_triangle();
      end else begin
        s = '{a: SW'($urandom), b: SW'($urandom), c: SW'($urandom)};
      end
      pending_q.push_back(s);
    end
  end

  // Driver: present pending triples, predict on acceptance
  always @(posedge clk_i) begin
    logic fire;
    logic hold;
    sides_t s;
    metrics_t m;
    fire = item_if.valid && item_if.ready;
    if (rst_ni) begin
      if (fire) begin
        m = triangle_metrics(pending_q[0]);
        metrics_q.push_back(m);
        if (m.proper) begin
          proper_cnt++;
          if (m.ang_a > 25736 || m.ang_b > 25736 || m.ang_c > 25736) obtuse_cnt++;
        end
        void'(pending_q.pop_front());
        accepted_cnt++;
      end
      hold = item_if.valid && !fire;
      if (!hold) begin
        if (accepted_cnt == DRAIN_AT && !drained) begin
          // Hold off until the pipeline is empty once
          if (metrics_q.size() == 0) drained = 1'b1;
          item_if.valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          item_if.valid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 15);
          item_if.valid <= 1'b0;
        end else begin
          s = pending_q[0];
          item_if.valid <= 1'b1;
          item_if.side_a <= s.a;
          item_if.side_b <= s.b;
          item_if.side_c <= s.c;
        end
      end
    end
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    metrics_t want;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (metrics_q.size() == 0) begin
          err_cnt++;
          $display("unexpected result item with nothing outstanding");
        end else begin
          want = metrics_q.pop_front();
          if (res_if.perimeter !== want.perimeter)
            report("perimeter", res_if.perimeter, want.perimeter);
          if (res_if.longest_side !== want.longest)
            report("longest_side", res_if.longest_side, want.longest);
          if (res_if.area !== want.area) report("area", res_if.area, want.area);
          if (res_if.angle_a !== want.ang_a) report("angle_a", res_if.angle_a, want.ang_a);
          if (res_if.angle_b !== want.ang_b) report("angle_b", res_if.angle_b, want.ang_b);
          if (res_if.angle_c !== want.ang_c) report("angle_c", res_if.angle_c, want.ang_c);
          if (res_if.valid_res !== want.proper)
            report("valid_res", res_if.valid_res, want.proper);
        end
        checked_cnt++;
      end
      // Stall the result side in bursts; no new burst starts in the tail
      if (recv_gap > 0) begin
        recv_gap--;
        res_if.ready <= 1'b0;
      end else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 15);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Sequence the run and close out
  initial begin
    err_cnt = 0;
    accepted_cnt = 0;
    checked_cnt = 0;
    proper_cnt = 0;
    obtuse_cnt = 0;
    cycle_cnt = 0;
    drained = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_q.size() != 0 || metrics_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("covered %0d triples (%0d proper, %0d obtuse), %0d results checked",
             accepted_cnt, proper_cnt, obtuse_cnt, checked_cnt);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
